>>> rtl/mts_pkg.sv
package mts_pkg;

  localparam int STACK_DEPTH_DEF = 1024;
  localparam int VALUE_BITS_DEF  = 32;

  localparam logic [1:0] ACT_PUSH = 2'd0;
  localparam logic [1:0] ACT_POP  = 2'd1;
  localparam logic [1:0] ACT_MIN  = 2'd2;
  localparam logic [1:0] ACT_NOP  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic op_start;    // execute the beat just accepted
    logic pop_finish;  // RAM data for a pop is valid this cycle
    logic load_out;    // move pending result into output register
  } mts_cmd_t;

  typedef struct packed {
    logic pop_read;    // accepted beat is a pop on a non-empty stack
  } mts_stat_t;

endpackage

>>> rtl/mts_in_if.sv
interface mts_in_if #(
  parameter int VALUE_BITS = mts_pkg::VALUE_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   action;
  logic signed [VALUE_BITS-1:0] push_value;

  modport source (output valid, output action, output push_value, input ready);
  modport sink   (input valid, input action, input push_value, output ready);
endinterface

>>> rtl/mts_out_if.sv
interface mts_out_if #(
  parameter int VALUE_BITS = mts_pkg::VALUE_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] result_value;
  logic [1:0]                   status;

  modport source (output valid, output result_value, output status, input ready);
  modport sink   (input valid, input result_value, input status, output ready);
endinterface

>>> rtl/mts_ram.sv
module mts_ram #(
  parameter int WIDTH = mts_pkg::VALUE_BITS_DEF + 2,
  parameter int DEPTH = mts_pkg::STACK_DEPTH_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/mts_ctrl.sv
module mts_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  mts_pkg::mts_stat_t stat,
  output mts_pkg::mts_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t state, state_next;
  logic   slot_free;

  assign slot_free      = !out_valid || out_ready;
  assign in_ready       = (state == S_IDLE);
  assign cmd.op_start   = in_valid && in_ready;
  assign cmd.pop_finish = (state == S_READ);
  assign cmd.load_out   = (state == S_EMIT) && slot_free;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.op_start) begin
          state_next = stat.pop_read ? S_READ : S_EMIT;
        end
      end
      S_READ: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/mts_datapath.sv
module mts_datapath #(
  parameter int STACK_DEPTH = mts_pkg::STACK_DEPTH_DEF,
  parameter int VALUE_BITS  = mts_pkg::VALUE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  mts_pkg::mts_cmd_t            cmd,
  output mts_pkg::mts_stat_t           stat,
  input  logic [1:0]                   action,
  input  logic signed [VALUE_BITS-1:0] push_value,
  output logic signed [VALUE_BITS-1:0] out_value,
  output logic [1:0]                   out_status
);

  localparam int EW = VALUE_BITS + 2;
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [CW-1:0]                count, count_next, cnt_dec;
  logic signed [VALUE_BITS-1:0] cur_min, cur_min_next;
  logic signed [VALUE_BITS-1:0] pend_value, pend_value_next;
  logic [1:0]                   pend_status, pend_status_next;

  logic          empty, full;
  logic signed [EW-1:0] val_e, min_e, enc, top, min_restore;
  logic          ram_we;
  logic [EW-1:0] ram_wdata, ram_rdata;

  assign empty   = (count == '0);
  assign full    = (count == CW'(STACK_DEPTH));
  assign cnt_dec = count - CW'(1);

  assign val_e       = {{2{push_value[VALUE_BITS-1]}}, push_value};
  assign min_e       = {{2{cur_min[VALUE_BITS-1]}}, cur_min};
  assign enc         = (val_e <<< 1) - min_e;
  assign top         = $signed(ram_rdata);
  assign min_restore = (min_e <<< 1) - top;

  assign stat.pop_read = (action == mts_pkg::ACT_POP) && !empty;

  mts_ram #(
    .WIDTH (EW),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[AW-1:0]),
    .wdata (ram_wdata),
    .raddr (cnt_dec[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    count_next       = count;
    cur_min_next     = cur_min;
    pend_value_next  = pend_value;
    pend_status_next = pend_status;
    ram_we           = 1'b0;
    ram_wdata        = val_e;

    if (cmd.op_start) begin
      pend_value_next  = '0;
      pend_status_next = mts_pkg::ST_OK;
      case (action)
        mts_pkg::ACT_PUSH: begin
          if (full) begin
            pend_status_next = mts_pkg::ST_FULL;
          end else begin
            ram_we     = 1'b1;
            count_next = count + CW'(1);
            if (empty) begin
              cur_min_next = push_value;
            end else if (push_value > cur_min) begin
              ram_wdata = val_e;
            end else begin
              // value at or below the minimum: store the encoded marker
              ram_wdata    = enc;
              cur_min_next = push_value;
            end
          end
        end
        mts_pkg::ACT_POP: begin
          if (empty) begin
            pend_status_next = mts_pkg::ST_EMPTY;
          end else begin
            count_next = cnt_dec;
          end
        end
        mts_pkg::ACT_MIN: begin
          if (empty) begin
            pend_status_next = mts_pkg::ST_EMPTY;
          end else begin
            pend_value_next = cur_min;
          end
        end
        default: begin
          pend_status_next = mts_pkg::ST_OK;
        end
      endcase
    end else if (cmd.pop_finish) begin
      if (top >= min_e) begin
        pend_value_next = top[VALUE_BITS-1:0];
      end else begin
        // marker entry: the minimum leaves, earlier one comes back
        pend_value_next = cur_min;
        cur_min_next    = min_restore[VALUE_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      cur_min <= {1'b0, {(VALUE_BITS-1){1'b1}}};
    end else begin
      count   <= count_next;
      cur_min <= cur_min_next;
    end
  end

  always_ff @(posedge clk) begin
    pend_value  <= pend_value_next;
    pend_status <= pend_status_next;
    if (cmd.load_out) begin
      out_value  <= pend_value;
      out_status <= pend_status;
    end
  end

endmodule

>>> rtl/min_tracking_stack.sv
// LIFO stack of signed values that also reports its current minimum, with no
// second stack: a push at or below the minimum stores 2*value-min as a marker
// and a pop that finds a marker restores the earlier minimum. Push, read
// minimum and the unused action code pass from acceptance through the pending
// result register into the output register once the output slot is free; a
// pop first goes through the READ state for the registered read port of the
// entry RAM. The next beat is accepted as soon as the previous result has moved
// into the output register, so one beat is in flight at a time. A full stack
// drops the push and reports full; pop or read minimum on an empty stack reports
// empty. The entry RAM needs no clearing after reset: only entries below the
// fill count are ever read.
module min_tracking_stack #(
  parameter int STACK_DEPTH = mts_pkg::STACK_DEPTH_DEF,
  parameter int VALUE_BITS  = mts_pkg::VALUE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  mts_in_if.sink     req,
  mts_out_if.source  rsp
);

  mts_pkg::mts_cmd_t  cmd;
  mts_pkg::mts_stat_t stat;

  mts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  mts_datapath #(
    .STACK_DEPTH (STACK_DEPTH),
    .VALUE_BITS  (VALUE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .action     (req.action),
    .push_value (req.push_value),
    .out_value  (rsp.result_value),
    .out_status (rsp.status)
  );

endmodule
